// ===== hdl/nnyd_pkg.sv =====
package nnyd_pkg;

   localparam int CoordWidth    = 18;
   localparam int MaxNeighbors  = 16;
   localparam int DistSqWidth   = 40;  // 3 * (19 bit diff)^2 fits in 40 bits
   localparam logic [DistSqWidth-1:0] FarLimitSq = 40'd250000;

   typedef enum logic [1:0] {
      CMD_OWN  = 2'd0,
      CMD_NBR  = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_OWN_PRIORITY  = 3'd0,
      CSR_OWN_RANK      = 3'd1,
      CSR_COLLISION     = 3'd2,
      CSR_PROXIMITY     = 3'd3,
      CSR_VERTICAL_SAFE = 3'd4,
      CSR_CLIMB_UP      = 3'd5
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_best;   // start a new scan
      logic read_entry;   // issue table read at scan index
      logic axis_n;       // square north diff
      logic axis_e;       // square east diff
      logic axis_u;       // square up diff, compare
      logic decide;       // compute the result from the winner
   } dp_cmd_type;

endpackage

// ===== hdl/nearest_neighbor_yield_decision.sv =====
// Nearest-neighbor yield decision. Issue an item with start while busy is low:
// command 0 loads own position, command 1 appends a neighbor (batch_start empties
// the table first; entries beyond capacity are dropped), command 2 evaluates.
// Commands 0, 1 and 3 give no result. A tick scans the table (up to 16 neighbors
// by default) through one shared squarer, stepping each stored neighbor through
// table read, then north, east, up, then enters the decide state (directly if no
// own position or neighbor is stored). The result appears on rsp_ for exactly
// one cycle with rsp_valid; the receiver cannot stall it and must take it then.
// CSR writes land at once and are meant only while the block is idle.
module nearest_neighbor_yield_decision #(
   parameter int MAX_NEIGHBORS = nnyd_pkg::MaxNeighbors
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [17:0] req_north_dm,
   input  logic signed [17:0] req_east_dm,
   input  logic signed [17:0] req_up_dm,
   input  logic [7:0]         req_other_priority,
   input  logic [7:0]         req_other_rank,
   input  logic               req_rank_known,
   input  logic               req_batch_start,
   output logic               rsp_valid,
   output logic [6:0]         rsp_speed_percent,
   output logic signed [4:0]  rsp_vertical_bias_dms,
   output logic               rsp_backoff_ok,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import nnyd_pkg::*;

   localparam int IdxW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CntW = $clog2(MAX_NEIGHBORS + 1);

   // configuration registers
   logic [7:0]  own_priority_ff, own_rank_ff;
   logic [15:0] collision_ff, proximity_ff, vsafe_ff;
   logic        climb_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_priority_ff <= 8'd100;
         own_rank_ff     <= 8'd0;
         collision_ff    <= 16'd80;
         proximity_ff    <= 16'd150;
         vsafe_ff        <= 16'd50;
         climb_up_ff     <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_OWN_PRIORITY:  own_priority_ff <= csr_data[7:0];
            CSR_OWN_RANK:      own_rank_ff     <= csr_data[7:0];
            CSR_COLLISION:     collision_ff    <= csr_data;
            CSR_PROXIMITY:     proximity_ff    <= csr_data;
            CSR_VERTICAL_SAFE: vsafe_ff        <= csr_data;
            CSR_CLIMB_UP:      climb_up_ff     <= csr_data[0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   dp_cmd_type       cmd;
   logic [IdxW-1:0]  scan_idx;
   logic             wr_own, wr_nbr;
   logic [CntW-1:0]  wr_idx;

   nnyd_ctrl #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .IDX_W(IdxW), .CNT_W(CntW)) u_ctrl (
      .clock, .reset, .start, .req_command, .req_batch_start,
      .busy, .rsp_valid, .cmd, .scan_idx, .wr_own, .wr_nbr, .wr_idx
   );

   nnyd_datapath #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .IDX_W(IdxW), .CNT_W(CntW)) u_dp (
      .clock, .cmd, .scan_idx, .wr_own, .wr_nbr, .wr_idx,
      .north_dm(req_north_dm), .east_dm(req_east_dm), .up_dm(req_up_dm),
      .other_priority(req_other_priority), .other_rank(req_other_rank),
      .rank_known(req_rank_known),
      .own_priority(own_priority_ff), .own_rank(own_rank_ff),
      .collision_dm(collision_ff), .proximity_dm(proximity_ff),
      .vertical_safe_dm(vsafe_ff), .climb_up(climb_up_ff),
      .speed_percent(rsp_speed_percent), .vertical_bias_dms(rsp_vertical_bias_dms),
      .backoff_ok(rsp_backoff_ok)
   );

endmodule

// ===== hdl/nnyd_datapath.sv =====
module nnyd_datapath #(
   parameter int MAX_NEIGHBORS = nnyd_pkg::MaxNeighbors,
   parameter int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
   parameter int CNT_W = $clog2(MAX_NEIGHBORS + 1)
) (
   input  logic                                 clock,
   input  nnyd_pkg::dp_cmd_type                 cmd,
   input  logic [IDX_W-1:0]                     scan_idx,
   input  logic                                 wr_own,
   input  logic                                 wr_nbr,
   input  logic [CNT_W-1:0]                     wr_idx,
   input  logic signed [17:0]                   north_dm,
   input  logic signed [17:0]                   east_dm,
   input  logic signed [17:0]                   up_dm,
   input  logic [7:0]                           other_priority,
   input  logic [7:0]                           other_rank,
   input  logic                                 rank_known,
   input  logic [7:0]                           own_priority,
   input  logic [7:0]                           own_rank,
   input  logic [15:0]                          collision_dm,
   input  logic [15:0]                          proximity_dm,
   input  logic [15:0]                          vertical_safe_dm,
   input  logic                                 climb_up,
   output logic [6:0]                           speed_percent,
   output logic signed [4:0]                    vertical_bias_dms,
   output logic                                 backoff_ok
);
   import nnyd_pkg::*;

   logic signed [17:0] own_n_ff, own_e_ff, own_u_ff;
   logic [53:0] pos_mem [MAX_NEIGHBORS];
   logic [16:0] id_mem  [MAX_NEIGHBORS];
   logic [53:0] pos_rd_ff;
   logic [16:0] id_rd_ff;

   logic [DistSqWidth-1:0] acc_ff, acc_in;
   logic [DistSqWidth-1:0] best_d2_ff;
   logic [16:0] best_id_ff;
   logic signed [18:0] best_dalt_ff;
   logic best_any_ff;

   logic signed [18:0] diff;
   logic [18:0] mag;
   logic [37:0] sq;

   always_ff @(posedge clock) begin
      if (wr_own) begin
         own_n_ff <= north_dm;
         own_e_ff <= east_dm;
         own_u_ff <= up_dm;
      end
      if (wr_nbr) begin
         pos_mem[wr_idx[IDX_W-1:0]] <= {north_dm, east_dm, up_dm};
         id_mem[wr_idx[IDX_W-1:0]]  <= {other_priority, other_rank, rank_known};
      end
      if (cmd.read_entry) begin
         pos_rd_ff <= pos_mem[scan_idx];
         id_rd_ff  <= id_mem[scan_idx];
      end
   end

   // one axis per cycle through a single squarer
   always_comb begin
      diff = '0;
      if (cmd.axis_n)
         diff = 19'(signed'(pos_rd_ff[53:36])) - 19'(own_n_ff);
      else if (cmd.axis_e)
         diff = 19'(signed'(pos_rd_ff[35:18])) - 19'(own_e_ff);
      else
         diff = 19'(signed'(pos_rd_ff[17:0])) - 19'(own_u_ff);
      mag = diff[18] ? 19'(-diff) : 19'(diff);
      sq  = mag * mag;
      acc_in = (cmd.axis_n ? '0 : acc_ff) + DistSqWidth'(sq);
   end

   always_ff @(posedge clock) begin
      if (cmd.axis_n || cmd.axis_e || cmd.axis_u)
         acc_ff <= acc_in;
      if (cmd.clear_best)
         best_any_ff <= 1'b0;
      else if (cmd.axis_u && (!best_any_ff || acc_in < best_d2_ff)) begin
         best_any_ff  <= 1'b1;
         best_d2_ff   <= acc_in;
         best_id_ff   <= id_rd_ff;
         best_dalt_ff <= 19'(signed'(pos_rd_ff[17:0])) - 19'(own_u_ff);
      end
   end

   // decision, registered into the output fields
   logic [31:0] c2, p2;
   logic [18:0] adalt;
   logic yield_now;
   logic [6:0] spd;
   logic signed [4:0] bias;
   logic rev;

   always_comb begin
      c2 = collision_dm * collision_dm;
      p2 = proximity_dm * proximity_dm;
      adalt = best_dalt_ff[18] ? 19'(-best_dalt_ff) : 19'(best_dalt_ff);
      yield_now = (own_priority < best_id_ff[16:9]) ||
                  (own_priority == best_id_ff[16:9] && own_rank > best_id_ff[8:1]);
      spd = 7'd100;
      bias = 5'sd0;
      rev = 1'b0;
      if (best_any_ff && best_d2_ff <= FarLimitSq && best_id_ff[0] && yield_now) begin
         if (best_d2_ff < DistSqWidth'(c2)) begin
            if (adalt < 19'(vertical_safe_dm)) begin
               bias = climb_up ? 5'sd15 : -5'sd15;
               if ((best_d2_ff * 40'd25) < (DistSqWidth'(c2) * 40'd9)) begin
                  spd = 7'd0;
                  rev = 1'b1;
               end else begin
                  spd = 7'd20;
               end
            end else begin
               bias = (best_dalt_ff > 0) ? -5'sd5 : 5'sd5;
            end
         end else if (best_d2_ff < DistSqWidth'(p2)) begin
            spd = 7'd50;
            if ({adalt, 1'b0} < 20'(vertical_safe_dm))
               bias = (best_dalt_ff > 0) ? -5'sd3 : 5'sd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         speed_percent     <= spd;
         vertical_bias_dms <= bias;
         backoff_ok        <= rev;
      end
   end

endmodule

// ===== hdl/nnyd_ctrl.sv =====
module nnyd_ctrl #(
   parameter int MAX_NEIGHBORS = nnyd_pkg::MaxNeighbors,
   parameter int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
   parameter int CNT_W = $clog2(MAX_NEIGHBORS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_command,
   input  logic                  req_batch_start,
   output logic                  busy,
   output logic                  rsp_valid,
   output nnyd_pkg::dp_cmd_type  cmd,
   output logic [IDX_W-1:0]      scan_idx,
   output logic                  wr_own,
   output logic                  wr_nbr,
   output logic [CNT_W-1:0]      wr_idx
);
   import nnyd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_AXN, ST_AXE, ST_AXU, ST_DECIDE
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic own_valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic rsp_valid_ff;
   logic accept;
   logic last;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_idx = idx_ff;
   assign last = (CNT_W'(idx_ff) + 1'b1 >= count_ff);

   always_comb begin
      count_in = (req_command == CMD_NBR && req_batch_start) ? '0 : count_ff;
      wr_own = accept && req_command == CMD_OWN;
      wr_nbr = accept && req_command == CMD_NBR && count_in < CNT_W'(MAX_NEIGHBORS);
      wr_idx = count_in;
      cmd = '0;
      cmd.clear_best = accept;
      cmd.read_entry = (state_ff == ST_READ);
      cmd.axis_n     = (state_ff == ST_AXN);
      cmd.axis_e     = (state_ff == ST_AXE);
      cmd.axis_u     = (state_ff == ST_AXU);
      cmd.decide     = (state_ff == ST_DECIDE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         own_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept) begin
                  case (req_command)
                     CMD_OWN:  own_valid_ff <= 1'b1;
                     CMD_NBR:  count_ff <= wr_nbr ? count_in + 1'b1 : count_in;
                     CMD_TICK: state_ff <= (own_valid_ff && count_ff != '0) ?
                                           ST_READ : ST_DECIDE;
                     default:  ;
                  endcase
               end
            end
            ST_READ:   state_ff <= ST_AXN;
            ST_AXN:    state_ff <= ST_AXE;
            ST_AXE:    state_ff <= ST_AXU;
            ST_AXU: begin
               if (last) state_ff <= ST_DECIDE;
               else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_DECIDE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/nnyd_checker.sv =====
module nnyd_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_command,
   input logic              rsp_valid,
   input logic [6:0]        rsp_speed_percent,
   input logic              rsp_backoff_ok
);
   import nnyd_pkg::*;

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_TICK) |=> busy)
      else $error("tick did not start work");

   a_other_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != CMD_TICK) |=> !busy && !rsp_valid)
      else $error("non-tick command made work");

   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("result not at end of work");

   a_rev_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_backoff_ok) |-> rsp_speed_percent == 7'd0)
      else $error("back-off without stop");

endmodule

bind nearest_neighbor_yield_decision nnyd_checker u_nnyd_checker (
   .clock, .reset, .start, .busy, .req_command, .rsp_valid,
   .rsp_speed_percent, .rsp_backoff_ok
);
